>>> rtl/rrsa_pkg.sv
// ----------------------------------------------------------------------------
// rrsa_pkg: shared definitions for the round-robin sample averager
// Field widths, defaults, register index, the queued item type and the
// status bundle that the engine returns to the front end.
// ----------------------------------------------------------------------------
package rrsa_pkg;

  // Fixed field widths of the streams and the register.
  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 3;
  localparam int CFG_W    = 3;
  localparam int NCH_W    = 4;  // effective channel count, up to MAX_CHANNELS
  localparam int NORM_W   = 16;
  localparam int FILL_W   = NORM_W - SAMPLE_W;

  // Stream and register port widths.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - SAMPLE_W - NORM_W;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_CHANNELS  = 5;
  localparam int DEF_ROUNDS        = 1024;
  localparam int DEF_AVERAGE_COUNT = 256;

  // Depth of the queue between front end and engine.
  localparam int QUEUE_DEPTH = 2;

  // Request kinds carried on in_tuser.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Register index and reset value.
  localparam logic             REG_NUM_CHANNELS = 1'b0;
  localparam logic [CFG_W-1:0] NUM_CHANNELS_RST = 3'd1;

  // One classified request waiting for the engine.
  typedef struct packed {
    logic                is_read;
    logic                chan_ok;
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   channel;
  } item_t;

  // Engine status seen by the front end.
  typedef struct packed {
    logic pop;       // head of the queue is consumed this cycle
    logic clearing;  // ring clear after reset is still running
  } eng_stat_t;

  // Shift-and-fill: the average moved up four bits, its top bits below.
  function automatic logic [NORM_W-1:0] normalize(input logic [SAMPLE_W-1:0] avg);
    return {avg, avg[SAMPLE_W-1 -: FILL_W]};
  endfunction

endpackage

>>> rtl/round_robin_sample_averager_core.sv
// ----------------------------------------------------------------------------
// round_robin_sample_averager_core: multichannel moving-average block
// Usage notes:
// The input stream carries one request per transfer: in_tuser low stores
// in_tdata's sample as the next round-robin ADC sample, in_tuser high asks
// for the average of the channel in in_tdata. Only a read produces a result
// on the output stream: average, its 16-bit shift-and-fill form, and
// channel_ok on out_tuser (zero data for a channel outside the count).
// The channel count is set over the register port while no request is in
// flight; a write also restarts the stream at the ring start.
// A stored sample passes through the queue and is written into the ring
// when the engine takes it; samples are taken one per cycle while no read
// is in progress. A read walks the channel's history through the single
// ring read port one entry per cycle, divides the sum by AVERAGE_COUNT and
// shows the result on out_tvalid; the engine then takes the next request.
// After reset the ring is cleared, all MAX_CHANNELS * ROUNDS entries
// (5120 by default), with in_tready low; register writes are taken then.
// A two-entry queue takes requests while the engine works, and a held
// result does not block stored samples; a read waits for the output slot.
// ----------------------------------------------------------------------------
module round_robin_sample_averager_core #(
  parameter int MAX_CHANNELS  = rrsa_pkg::DEF_MAX_CHANNELS,
  parameter int ROUNDS        = rrsa_pkg::DEF_ROUNDS,
  parameter int AVERAGE_COUNT = rrsa_pkg::DEF_AVERAGE_COUNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rrsa_pkg::IN_DATA_W-1:0]  in_tdata,    // sample[11:0], channel[14:12]
  input  logic                            in_tuser,    // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rrsa_pkg::OUT_DATA_W-1:0] out_tdata,   // average[11:0], normalized[27:12]
  output logic                            out_tuser,   // channel_ok
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rrsa_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [rrsa_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [rrsa_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import rrsa_pkg::*;

  logic [CFG_W-1:0]    num_channels_r;
  logic [NCH_W-1:0]    n_eff;
  logic                reg_sel;
  logic                cfg_wr;
  logic                q_valid;
  item_t               q_item;
  eng_stat_t           stat;
  logic [SAMPLE_W-1:0] avg;

  // Register port: a single register at word zero.
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[APB_ADDR_W-1:2] == REG_NUM_CHANNELS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel;
  assign cfg_prdata = reg_sel ? APB_DATA_W'(num_channels_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_channels_r <= NUM_CHANNELS_RST;
    end else if (cfg_wr) begin
      num_channels_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // Effective channel count, saturated to 1..MAX_CHANNELS.
  always_comb begin
    if (num_channels_r == '0) begin
      n_eff = NCH_W'(1);
    end else if (NCH_W'(num_channels_r) > NCH_W'(MAX_CHANNELS)) begin
      n_eff = NCH_W'(MAX_CHANNELS);
    end else begin
      n_eff = NCH_W'(num_channels_r);
    end
  end

  rrsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .n_eff     (n_eff),
    .stat      (stat),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  rrsa_engine #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .ROUNDS        (ROUNDS),
    .AVERAGE_COUNT (AVERAGE_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_eff     (n_eff),
    .cfg_wr    (cfg_wr),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_avg   (avg),
    .out_ok    (out_tuser)
  );

  // Result packing.
  assign out_tdata = {OUT_PAD_W'(0), normalize(avg), avg};

endmodule

>>> rtl/rrsa_front.sv
// ----------------------------------------------------------------------------
// rrsa_front: request intake and classification
// Accepts requests from the input stream, marks reads whose channel is in
// range, and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module rrsa_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rrsa_pkg::IN_DATA_W-1:0] in_tdata,   // sample[11:0], channel[14:12]
  input  logic                          in_tuser,   // action
  input  logic [rrsa_pkg::NCH_W-1:0]    n_eff,
  input  rrsa_pkg::eng_stat_t           stat,
  output logic                          q_valid,
  output rrsa_pkg::item_t               q_item
);
  import rrsa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  item_t            in_item;
  logic             push;
  logic             pop;

  // Unpack the request and decide whether a read targets a live channel.
  always_comb begin
    in_item.is_read = (in_tuser == ACT_READ);
    in_item.sample  = in_tdata[SAMPLE_W-1:0];
    in_item.channel = in_tdata[SAMPLE_W +: CHAN_W];
    in_item.chan_ok = (NCH_W'(in_item.channel) < n_eff);
  end

  // Nothing enters while the ring is being cleared.
  assign in_tready = (cnt_r != CNT_W'(QUEUE_DEPTH)) && !stat.clearing;
  assign push      = in_tvalid && in_tready;
  assign pop       = stat.pop;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_mem_r[rd_ptr_r];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

>>> rtl/rrsa_engine.sv
// ----------------------------------------------------------------------------
// rrsa_engine: sample ring and averaging engine
// Owns the sample ring, stores samples, walks one channel's history for a
// read, divides the sum by the average count and holds the result.
// ----------------------------------------------------------------------------
module rrsa_engine #(
  parameter int MAX_CHANNELS  = rrsa_pkg::DEF_MAX_CHANNELS,
  parameter int ROUNDS        = rrsa_pkg::DEF_ROUNDS,
  parameter int AVERAGE_COUNT = rrsa_pkg::DEF_AVERAGE_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rrsa_pkg::NCH_W-1:0]    n_eff,
  input  logic                          cfg_wr,
  input  logic                          q_valid,
  input  rrsa_pkg::item_t               q_item,
  output rrsa_pkg::eng_stat_t           stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rrsa_pkg::SAMPLE_W-1:0] out_avg,
  output logic                          out_ok
);
  import rrsa_pkg::*;

  localparam int RING_DEPTH = MAX_CHANNELS * ROUNDS;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int SIZE_W     = $clog2(RING_DEPTH + 1);
  localparam int ACC_W      = SAMPLE_W + $clog2(AVERAGE_COUNT + 1);
  localparam int WCNT_W     = $clog2(AVERAGE_COUNT + 1);

  // Scaled reciprocal of the average count: exact floor division for every
  // sum that fits the accumulator.
  localparam int RECIP_SH = ACC_W + $clog2(AVERAGE_COUNT);
  localparam int RECIP_W  = ACC_W + 1;
  localparam int PROD_W   = ACC_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(AVERAGE_COUNT - 1)) / 64'(AVERAGE_COUNT));

  localparam int         STATE_W  = 3;
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_LAST  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [STATE_W-1:0]  state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [ADDR_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [NCH_W-1:0]    col_r, col_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [WCNT_W-1:0]   wcnt_r, wcnt_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                ok_r, ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_avg_r, out_avg_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [SIZE_W-1:0]   size_r;

  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;

  logic [SIZE_W-1:0]   base_pos;
  logic [PROD_W-1:0]   quot_prod;
  logic [ACC_W-1:0]    quot;

  // One round back from a ring position, wrapping below zero.
  function automatic logic [ADDR_W-1:0] step_back(input logic [ADDR_W-1:0] pos,
                                                  input logic [NCH_W-1:0]  n,
                                                  input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] p;
    logic [SIZE_W-1:0] nn;
    p  = SIZE_W'(pos);
    nn = SIZE_W'(n);
    return (p >= nn) ? ADDR_W'(p - nn) : ADDR_W'(p + size - nn);
  endfunction

  // Ring size follows the channel count; the user must change it only while idle, unchecked by the block.
  always_ff @(posedge clk) begin
    size_r <= SIZE_W'(int'(n_eff) * ROUNDS);
  end

  // Requested channel's slot in the round being written, one round past the newest complete one.
  assign base_pos = SIZE_W'(wr_idx_r) - SIZE_W'(col_r) + SIZE_W'(q_item.channel);

  // Division by the average count as a multiply by its scaled reciprocal.
  assign quot_prod = PROD_W'(acc_r) * PROD_W'(RECIP);
  assign quot      = ACC_W'(quot_prod >> RECIP_SH);

  // Ring write port: clearing pass or a stored sample.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx_r;
    mem_wdata = q_item.sample;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else if (state_r == ST_IDLE && q_valid && !q_item.is_read) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= ring_mem[pos_r];
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    wr_idx_nxt    = wr_idx_r;
    col_nxt       = col_r;
    pos_nxt       = pos_r;
    wcnt_nxt      = wcnt_r;
    rd_pend_nxt   = 1'b0;
    acc_nxt       = acc_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_avg_nxt   = out_avg_r;
    out_ok_nxt    = out_ok_r;
    stat.pop      = 1'b0;
    stat.clearing = (state_r == ST_CLEAR);

    // Read data lands in the cycle after its address went out.
    if (rd_pend_r) begin
      acc_nxt = acc_r + ACC_W'(rd_data_r);
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == ADDR_W'(RING_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          stat.pop = 1'b1;
          if (!q_item.is_read) begin
            wr_idx_nxt = (SIZE_W'(wr_idx_r) + 1'b1 == size_r) ? '0 : wr_idx_r + 1'b1;
            col_nxt    = (col_r + 1'b1 == n_eff) ? '0 : col_r + 1'b1;
          end else if (q_item.chan_ok) begin
            pos_nxt   = step_back(ADDR_W'(base_pos), n_eff, size_r);
            acc_nxt   = '0;
            wcnt_nxt  = '0;
            ok_nxt    = 1'b1;
            state_nxt = ST_WALK;
          end else begin
            acc_nxt   = '0;
            ok_nxt    = 1'b0;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_WALK: begin
        pos_nxt     = step_back(pos_r, n_eff, size_r);
        rd_pend_nxt = 1'b1;
        wcnt_nxt    = wcnt_r + 1'b1;
        if (wcnt_r == WCNT_W'(AVERAGE_COUNT - 1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        acc_nxt   = quot;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = acc_r[SAMPLE_W-1:0];
          out_ok_nxt    = ok_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // A channel count write restarts the stream at the ring start.
    if (cfg_wr) begin
      wr_idx_nxt = '0;
      col_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      wr_idx_r    <= '0;
      col_r       <= '0;
      wcnt_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      col_r       <= col_nxt;
      wcnt_r      <= wcnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    acc_r     <= acc_nxt;
    ok_r      <= ok_nxt;
    out_avg_r <= out_avg_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_avg   = out_avg_r;
  assign out_ok    = out_ok_r;

endmodule

>>> rtl/rrsa_checker.sv
// ----------------------------------------------------------------------------
// rrsa_checker: port-level checks for the sample averager
// Watches the top-level ports over time and flags result and reset
// behavior that the block must never show.
// ----------------------------------------------------------------------------
module rrsa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rrsa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import rrsa_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A rejected channel carries all-zero data.
  a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("rejected channel returned nonzero data");

  // The normalized field is the shift-and-fill of the average.
  a_norm_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SAMPLE_W +: NORM_W] == normalize(out_tdata[SAMPLE_W-1:0]))
    else $error("normalized field does not match average");

  // Right after reset the ring is being cleared: no intake, no result.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block active right after reset");

endmodule

bind round_robin_sample_averager_core rrsa_checker u_rrsa_checker (.*);

>>> tb/sv/rrsa_avg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsa_avg_checker: result predictor and scoreboard for the sample averager
// Watches the request, result and register channels. It keeps its own copy
// of the sample ring, the write position and the channel count. For every
// accepted read request it computes the expected average. Each accepted
// result is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module rrsa_avg_checker
  import rrsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // sample[11:0], channel[14:12]
  input  logic                  in_tuser,    // action
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,   // average[11:0], normalized[27:12]
  input  logic                  out_tuser,   // channel_ok
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    failures,
  output int                    pending
);

  localparam int RING_DEPTH = DEF_MAX_CHANNELS * DEF_ROUNDS;
  localparam logic [APB_ADDR_W-1:0] NUM_CHANNELS_ADDR = APB_ADDR_W'(4 * REG_NUM_CHANNELS);

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [NORM_W-1:0]   normalized;
    logic                channel_ok;
  } avg_result_t;

  logic [SAMPLE_W-1:0] sample_mem [RING_DEPTH];
  int unsigned         next_slot;
  logic [CFG_W-1:0]    chan_cfg;
  avg_result_t         expected_averages [$];

  // Channel count as the block uses it: zero acts as one, large values clamp.
  function automatic int unsigned active_channels();
    int unsigned n;
    n = chan_cfg;
    if (n < 1) n = 1;
    if (n > DEF_MAX_CHANNELS) n = DEF_MAX_CHANNELS;
    return n;
  endfunction

  // Walk back one round at a time from the last complete round and average.
  function automatic avg_result_t predict_average(input logic [CHAN_W-1:0] ch,
                                                  input int unsigned n);
    avg_result_t res;
    int unsigned ring_size;
    int unsigned pos;
    int unsigned total;
    res = '0;
    if (ch >= n) return res;
    ring_size = n * DEF_ROUNDS;
    total = 0;
    pos = (next_slot / n) * n + ch;
    pos = (pos >= n) ? pos - n : pos + ring_size - n;
    for (int i = 0; i < DEF_AVERAGE_COUNT; i++) begin
      total += sample_mem[pos];
      pos = (pos >= n) ? pos - n : pos + ring_size - n;
    end
    res.average    = SAMPLE_W'(total / DEF_AVERAGE_COUNT);
    res.normalized = (NORM_W'(res.average) << FILL_W) |
                     NORM_W'(res.average >> (SAMPLE_W - FILL_W));
    res.channel_ok = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    avg_result_t want;
    int unsigned n;
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) sample_mem[i] = '0;
      next_slot = 0;
      chan_cfg  = NUM_CHANNELS_RST;
      expected_averages.delete();
      failures  = 0;
    end else begin
      // Results are matched first, so a result never pairs with a request
      // accepted at the same edge.
      if (out_tvalid && out_tready) begin
        if (expected_averages.size() == 0) begin
          if (failures < 10)
            $display("%0t checker: result with none expected: avg=%0d norm=%0h ok=%0b",
                     $realtime, out_tdata[SAMPLE_W-1:0],
                     out_tdata[SAMPLE_W +: NORM_W], out_tuser);
          failures++;
        end else begin
          want = expected_averages.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== want.average ||
              out_tdata[SAMPLE_W +: NORM_W] !== want.normalized ||
              out_tuser !== want.channel_ok) begin
            if (failures < 10)
              $display("%0t checker: mismatch avg exp %0d got %0d, norm exp %0h got %0h, ok exp %0b got %0b",
                       $realtime, want.average, out_tdata[SAMPLE_W-1:0],
                       want.normalized, out_tdata[SAMPLE_W +: NORM_W],
                       want.channel_ok, out_tuser);
            failures++;
          end
        end
      end

      // A channel count write restarts the stream at the ring start.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == NUM_CHANNELS_ADDR) begin
        chan_cfg  = cfg_pwdata[CFG_W-1:0];
        next_slot = 0;
      end

      // Store a sample, or queue the expected average for a read request.
      if (in_tvalid && in_tready) begin
        n = active_channels();
        if (next_slot >= n * DEF_ROUNDS) next_slot = 0;
        if (in_tuser == ACT_SAMPLE) begin
          sample_mem[next_slot] = in_tdata[SAMPLE_W-1:0];
          next_slot++;
          if (next_slot >= n * DEF_ROUNDS) next_slot = 0;
        end else begin
          expected_averages.push_back(predict_average(in_tdata[SAMPLE_W +: CHAN_W], n));
        end
      end
    end
    pending = expected_averages.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the round-robin sample averager
// Resets the block, runs a short directed sequence over extreme samples,
// out-of-range channels and channel count changes, then random phases at
// every channel count setting with varying sender gaps and receiver stalls.
// Checking is done by the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import rrsa_pkg::*;

  localparam logic [APB_ADDR_W-1:0] NUM_CHANNELS_ADDR = APB_ADDR_W'(4 * REG_NUM_CHANNELS);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = ACT_SAMPLE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int failures;
  int pending;
  int sent_requests = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  always #1 clk = ~clk;

  round_robin_sample_averager_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  rrsa_avg_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .failures    (failures),
    .pending     (pending)
  );

  // Receiver back-pressure follows the current idle mode.
  always @(negedge clk) begin
    out_tready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
  end

  // Send one request, with random sender gaps before it; returns on acceptance.
  task automatic push_request(input logic act, input logic [IN_DATA_W-1:0] data);
    case ((sent_requests / 40) % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
      default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
    endcase
    sent_requests++;
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
  endtask

  // The unused field of each request carries random bits.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    push_request(ACT_SAMPLE, {1'b0, CHAN_W'($urandom), value});
  endtask

  task automatic send_read(input logic [CHAN_W-1:0] ch);
    push_request(ACT_READ, {1'b0, ch, SAMPLE_W'($urandom)});
  endtask

  // Hold off the sender until every expected result is in, then let queued
  // sample stores finish.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_num_channels(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= NUM_CHANNELS_ADDR;
    cfg_pwdata  <= {(APB_DATA_W - CFG_W)'($urandom), value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // One random phase at a given channel count; reads are read_pct percent.
  task automatic run_phase(input logic [CFG_W-1:0] ch_cfg, input int count,
                           input int read_pct);
    int eff;
    logic [SAMPLE_W-1:0] value;
    eff = (ch_cfg == 0) ? 1 : (ch_cfg > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : ch_cfg;
    wait_drained();
    write_num_channels(ch_cfg);
    for (int k = 0; k < count; k++) begin
      // Partway through, the sender waits for all results to come back.
      if (k == count / 2) wait_drained();
      if ($urandom_range(99) < read_pct) begin
        if ($urandom_range(4) == 0) send_read(CHAN_W'($urandom_range(7)));
        else send_read(CHAN_W'($urandom_range(eff - 1)));
      end else begin
        case ($urandom_range(9))
          0: value = '0;
          1: value = '1;
          default: value = SAMPLE_W'($urandom);
        endcase
        send_sample(value);
      end
    end
  endtask

  // Watchdog for a hung run.
  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The register is taken while the ring is still being cleared.
    write_num_channels(NUM_CHANNELS_RST);

    // Single channel: empty ring, out-of-range channel, a few full-scale samples.
    send_read(3'd0);
    send_read(3'd7);
    repeat (4) send_sample(12'hFFF);
    send_sample(12'h000);
    send_read(3'd0);
    send_read(3'd1);

    // Five channels: the index restarts while the old ring contents stay.
    wait_drained();
    write_num_channels(3'd5);
    send_read(3'd4);
    send_read(3'd5);
    send_sample(12'hFFF);
    send_sample(12'h800);
    send_sample(12'h001);
    send_sample(12'h7FF);
    send_sample(12'hAAA);
    send_read(3'd0);
    send_read(3'd4);
    send_read(3'd6);

    // A count of zero acts as one channel.
    wait_drained();
    write_num_channels(3'd0);
    send_read(3'd0);
    send_read(3'd1);

    // Long single-channel phase, then every other count setting including
    // the clamped ones.
    run_phase(3'd1, 510, 6);
    run_phase(3'd3, 60, 20);
    run_phase(3'd7, 60, 20);
    run_phase(3'd2, 60, 20);
    run_phase(3'd0, 60, 20);
    run_phase(3'd4, 60, 20);
    run_phase(3'd6, 60, 20);
    run_phase(3'd5, 60, 20);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
